@@ hw/rtl/lamp_dimmer_command_controller_macros.svh @@
// -----------------------------------------------------------------------------
// Lamp dimmer controller assertion macros
// Shared assertion forms used by the controller's top level.
// -----------------------------------------------------------------------------
`ifndef LAMP_DIMMER_COMMAND_CONTROLLER_MACROS_SVH
`define LAMP_DIMMER_COMMAND_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LDCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LDCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ldcc_pkg.sv @@
// -----------------------------------------------------------------------------
// Lamp dimmer controller package
// Codes, register indexes, reset values and shared types.
// -----------------------------------------------------------------------------
package ldcc_pkg;

	localparam logic [1:0] EV_TICK   = 2'd0;
	localparam logic [1:0] EV_CMD    = 2'd1;
	localparam logic [1:0] EV_REPORT = 2'd2;

	localparam logic [3:0] CMD_ON        = 4'd2;
	localparam logic [3:0] CMD_OFF       = 4'd3;
	localparam logic [3:0] CMD_GO_FIRST  = 4'd4;
	localparam logic [3:0] CMD_GO_SECOND = 4'd5;
	localparam logic [3:0] CMD_GO_ANY    = 4'd6;
	localparam logic [3:0] CMD_DIM_START = 4'd7;
	localparam logic [3:0] CMD_KEEPALIVE = 4'd8;
	localparam logic [3:0] CMD_DIM_STOP  = 4'd9;

	localparam logic [1:0] REP_OFF   = 2'd0;
	localparam logic [1:0] REP_ON    = 2'd1;
	localparam logic [1:0] REP_LEVEL = 2'd2;

	localparam logic [2:0] ACT_NONE   = 3'd0;
	localparam logic [2:0] ACT_SEND   = 3'd1;
	localparam logic [2:0] ACT_POS1   = 3'd2;
	localparam logic [2:0] ACT_POS2   = 3'd3;
	localparam logic [2:0] ACT_RANDOM = 3'd4;

	localparam logic [1:0] REG_STEP_SIZE = 2'd0;
	localparam logic [1:0] REG_TIMEOUT   = 2'd1;
	localparam logic [1:0] REG_INTERVAL  = 2'd2;
	localparam logic [1:0] REG_DEFAULT   = 2'd3;

	localparam logic [7:0]  RST_STEP_SIZE = 8'd16;
	localparam logic [15:0] RST_TIMEOUT   = 16'd900;
	localparam logic [15:0] RST_INTERVAL  = 16'd180;
	localparam logic [7:0]  RST_LEVEL     = 8'd160;
	localparam logic [7:0]  LEVEL_MAX     = 8'd255;

	// Lamp state that the item logic reads and rewrites.
	typedef struct packed {
		logic [7:0] level;
		logic       lit;
		logic [7:0] remembered;
		logic       dim_active;
		logic       dir_up;
	} lamp_t;

	// Decisions taken from the timers and the duplicate filter.
	typedef struct packed {
		logic step;
		logic timeout;
		logic cmd_ok;
	} ctl_t;

endpackage

@@ hw/rtl/lamp_dimmer_command_controller.sv @@
// -----------------------------------------------------------------------------
// Lamp dimmer command controller
// An accepted item passes the input register, then the result register. One
// item per cycle is sustained while res_stall stays low, set by the single
// state update between the two registers. Reset clears all lamp state to its
// initial values and loads the register defaults; no clearing pass is needed.
// -----------------------------------------------------------------------------
`include "lamp_dimmer_command_controller_macros.svh"

module lamp_dimmer_command_controller import ldcc_pkg::*; #(
	parameter int AGE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Item channel.
	input  logic        evt_valid,
	output logic        evt_stall,
	input  logic [1:0]  event_kind,
	input  logic [3:0]  command,
	input  logic        packet_ok,
	input  logic [7:0]  session_id,
	input  logic [15:0] sequence_number,
	input  logic [1:0]  report_kind,
	input  logic [7:0]  report_level,
	// Result channel.
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  level,
	output logic        lamp_on,
	output logic [2:0]  action,
	output logic        dimming,
	output logic        dim_upward
);

	// The age compare runs at the wider of the age counters and the 16-bit
	// timer registers, so any AGE_BITS in range compares correctly.
	localparam int CMP_W = (AGE_BITS > 16) ? AGE_BITS : 16;

	// Configuration registers. Writes are always taken; the user only writes
	// while the block is idle.
	logic [7:0]  step_size_q;
	logic [15:0] timeout_q;
	logic [15:0] interval_q;
	logic [7:0]  default_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_size_q <= RST_STEP_SIZE;
			timeout_q   <= RST_TIMEOUT;
			interval_q  <= RST_INTERVAL;
			default_q   <= RST_LEVEL;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STEP_SIZE: step_size_q <= cfg_data[7:0];
				REG_TIMEOUT:   timeout_q   <= cfg_data;
				REG_INTERVAL:  interval_q  <= cfg_data;
				REG_DEFAULT:   default_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register. It holds one item; the result register takes it when the
	// result side is free or drains that cycle, so items flow every unstalled cycle.
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [3:0]  cmd_s1;
	logic        ok_s1;
	logic [7:0]  sess_s1;
	logic [15:0] seq_s1;
	logic [1:0]  rkind_s1;
	logic [7:0]  rlevel_s1;
	logic        res_valid_q;
	logic        advance;
	logic        fire;
	logic        evt_take;

	assign advance   = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && advance;
	assign evt_stall = valid_s1 && !advance;
	assign evt_take  = evt_valid && !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_take) begin
			kind_s1   <= event_kind;
			cmd_s1    <= command;
			ok_s1     <= packet_ok;
			sess_s1   <= session_id;
			seq_s1    <= sequence_number;
			rkind_s1  <= report_kind;
			rlevel_s1 <= report_level;
		end
	end

	// Controller state.
	lamp_t                lamp_q;
	logic [7:0]           prev_sess_q;
	logic [15:0]          prev_seq_q;
	logic [AGE_BITS-1:0]  ka_age_q;
	logic [AGE_BITS-1:0]  step_age_q;
	logic                 step_due_q;

	// Both ages advance on every tick and stick at their all-ones value.
	logic [AGE_BITS-1:0]  ka_inc;
	logic [AGE_BITS-1:0]  step_inc;
	logic                 is_tick;
	logic                 is_cmd;
	logic                 timed_out;
	logic                 step_ready;
	ctl_t                 ctl;
	lamp_t                lamp_nxt;
	logic [2:0]           action_nxt;

	assign ka_inc   = (&ka_age_q) ? ka_age_q : ka_age_q + AGE_BITS'(1);
	assign step_inc = (&step_age_q) ? step_age_q : step_age_q + AGE_BITS'(1);
	assign is_tick  = (kind_s1 == EV_TICK);
	assign is_cmd   = (kind_s1 == EV_CMD);

	// A keepalive silence beyond the timeout wins over a due step.
	assign timed_out  = CMP_W'(ka_inc) > CMP_W'(timeout_q);
	assign step_ready = step_due_q || (CMP_W'(step_inc) >= CMP_W'(interval_q));

	assign ctl.timeout = is_tick && lamp_q.dim_active && timed_out;
	assign ctl.step    = is_tick && lamp_q.dim_active && !timed_out && step_ready;
	// A command counts only if the packet passed its check and is not a repeat
	// of the last accepted session and sequence pair.
	assign ctl.cmd_ok  = is_cmd && ok_s1 &&
		!((sess_s1 == prev_sess_q) && (seq_s1 == prev_seq_q));

	ldcc_lamp u_lamp (
		.event_kind    (kind_s1),
		.command       (cmd_s1),
		.report_kind   (rkind_s1),
		.report_level  (rlevel_s1),
		.ctl           (ctl),
		.dim_step_size (step_size_q),
		.default_level (default_q),
		.cur           (lamp_q),
		.nxt           (lamp_nxt),
		.action        (action_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lamp_q      <= '{level: RST_LEVEL, lit: 1'b0, remembered: RST_LEVEL,
				dim_active: 1'b0, dir_up: 1'b1};
			prev_sess_q <= '0;
			prev_seq_q  <= '0;
			ka_age_q    <= '0;
			step_age_q  <= '0;
			step_due_q  <= 1'b0;
		end else if (fire) begin
			lamp_q <= lamp_nxt;
			if (is_tick) begin
				ka_age_q   <= ka_inc;
				step_age_q <= ctl.step ? '0 : step_inc;
				if (ctl.step) begin
					step_due_q <= 1'b0;
				end
			end
			if (ctl.cmd_ok) begin
				prev_sess_q <= sess_s1;
				prev_seq_q  <= seq_s1;
				// Dim start arms an immediate step on the next tick; a keepalive
				// only restarts the silence timer.
				if (cmd_s1 == CMD_DIM_START) begin
					ka_age_q   <= '0;
					step_due_q <= 1'b1;
				end else if (cmd_s1 == CMD_KEEPALIVE) begin
					ka_age_q <= '0;
				end
			end
		end
	end

	// Result register. It shows the state after the item and its action.
	logic [7:0] level_q;
	logic       lamp_on_q;
	logic [2:0] action_q;
	logic       dimming_q;
	logic       dim_upward_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			level_q      <= lamp_nxt.level;
			lamp_on_q    <= lamp_nxt.lit;
			action_q     <= action_nxt;
			dimming_q    <= lamp_nxt.dim_active;
			dim_upward_q <= lamp_nxt.dir_up;
		end
	end

	assign res_valid  = res_valid_q;
	assign level      = level_q;
	assign lamp_on    = lamp_on_q;
	assign action     = action_q;
	assign dimming    = dimming_q;
	assign dim_upward = dim_upward_q;

	// A lit lamp never reports a zero level.
	`LDCC_ASSERT_SAME(a_lit_nonzero, clk, arst_n, res_valid_q && lamp_on_q, level_q != 8'd0, "lit lamp at level zero")
	// The remembered level is never zero, so the fallback chain always ends.
	`LDCC_ASSERT_SAME(a_remembered_nonzero, clk, arst_n, 1'b1, lamp_q.remembered != 8'd0, "remembered level is zero")
	// An item that moves forward always shows up as a result next cycle.
	`LDCC_ASSERT_NEXT(a_fire_result, clk, arst_n, fire, res_valid_q, "accepted item produced no result")

endmodule

@@ hw/rtl/ldcc_lamp.sv @@
// -----------------------------------------------------------------------------
// Lamp state update
// Next lamp state and action for one item, given the timer decisions.
// -----------------------------------------------------------------------------
module ldcc_lamp import ldcc_pkg::*; (
	input  logic [1:0] event_kind,
	input  logic [3:0] command,
	input  logic [1:0] report_kind,
	input  logic [7:0] report_level,
	input  ctl_t       ctl,
	input  logic [7:0] dim_step_size,
	input  logic [7:0] default_level,
	input  lamp_t      cur,
	output lamp_t      nxt,
	output logic [2:0] action
);

	logic [7:0] fallback;
	logic [7:0] base;
	logic [8:0] sum_up;
	logic [7:0] stepped;
	logic       set_en;
	logic       set_on;
	logic [7:0] set_lvl;

	assign fallback = (cur.remembered != 8'd0) ? cur.remembered : default_level;
	assign base     = cur.lit ? cur.level : fallback;
	assign sum_up   = {1'b0, base} + {1'b0, dim_step_size};

	always_comb begin
		if (cur.dir_up) begin
			stepped = sum_up[8] ? LEVEL_MAX : sum_up[7:0];
		end else begin
			stepped = (dim_step_size > base) ? 8'd0 : base - dim_step_size;
		end
	end

	always_comb begin
		nxt     = cur;
		action  = ACT_NONE;
		set_en  = 1'b0;
		set_on  = 1'b0;
		set_lvl = cur.level;
		unique case (event_kind)
			EV_TICK: begin
				if (ctl.timeout) begin
					nxt.dim_active = 1'b0;
					nxt.dir_up     = ~cur.dir_up;
				end else if (ctl.step) begin
					set_en  = 1'b1;
					set_on  = 1'b1;
					set_lvl = stepped;
					action  = ACT_SEND;
				end
			end
			EV_CMD: begin
				if (ctl.cmd_ok) begin
					unique case (command)
						CMD_ON: begin
							set_en  = 1'b1;
							set_on  = 1'b1;
							set_lvl = (cur.level != 8'd0) ? cur.level : fallback;
							action  = ACT_SEND;
						end
						CMD_OFF: begin
							set_en = 1'b1;
							action = ACT_SEND;
						end
						CMD_GO_FIRST:  action = ACT_POS1;
						CMD_GO_SECOND: action = ACT_POS2;
						CMD_GO_ANY:    action = ACT_RANDOM;
						CMD_DIM_START, CMD_KEEPALIVE: nxt.dim_active = 1'b1;
						CMD_DIM_STOP: begin
							if (cur.dim_active) begin
								nxt.dim_active = 1'b0;
								nxt.dir_up     = ~cur.dir_up;
							end
						end
						default: ;
					endcase
				end
			end
			EV_REPORT: begin
				unique case (report_kind)
					REP_OFF: set_en = 1'b1;
					REP_ON: begin
						set_en  = 1'b1;
						set_on  = 1'b1;
						set_lvl = fallback;
					end
					REP_LEVEL: begin
						set_en  = 1'b1;
						set_on  = 1'b1;
						set_lvl = report_level;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		if (set_en) begin
			nxt.level = set_lvl;
			nxt.lit   = set_on && (set_lvl != 8'd0);
			if (set_lvl != 8'd0) begin
				nxt.remembered = set_lvl;
			end
		end
	end

endmodule

@@ verif/testbench.sv @@
// -----------------------------------------------------------------------------
// Lamp dimmer command controller testbench
// Drives ticks, radio commands and lamp reports through the item channel and
// checks every result against a cycle-free model of the lamp state or, for
// directed rows, a typed-in result. A short table of directed items comes
// first. Random phases follow under several register settings and idle mixes.
// -----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ldcc_pkg::*;

	// Age counter width, matched to the instance parameter below.
	localparam int AGE_W = 16;

	// Codes that have no name in the package.
	localparam logic [1:0] EV_SPARE   = 2'd3;
	localparam logic [1:0] REP_SPARE  = 2'd3;
	localparam logic [3:0] CMD_IDLE   = 4'd0;
	localparam logic [3:0] CMD_STATE  = 4'd1;
	localparam logic [3:0] CMD_SPARE  = 4'd15;

	// Table rows either carry a typed-in result or defer to the lamp model.
	localparam logic BY_MODEL = 1'b0;
	localparam logic TYPED    = 1'b1;

	// One result item as the block presents it.
	typedef struct packed {
		logic [7:0] level;
		logic       lit;
		logic [2:0] act;
		logic       dim;
		logic       up;
	} lamp_result_t;

	// One input item, plus the typed-in result for directed rows.
	typedef struct packed {
		logic [1:0]   kind;
		logic [3:0]   cmd;
		logic         ok;
		logic [7:0]   sess;
		logic [15:0]  seq;
		logic [1:0]   rkind;
		logic [7:0]   rlevel;
		logic         fixed;
		lamp_result_t want;
	} lamp_item_t;

	// Every input of the block has a known value from time zero.
	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        cfg_valid       = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index       = '0;
	logic [15:0] cfg_data        = '0;
	logic        evt_valid       = 1'b0;
	logic        evt_stall;
	logic [1:0]  event_kind      = '0;
	logic [3:0]  command         = '0;
	logic        packet_ok       = 1'b0;
	logic [7:0]  session_id      = '0;
	logic [15:0] sequence_number = '0;
	logic [1:0]  report_kind     = '0;
	logic [7:0]  report_level    = '0;
	logic        res_valid;
	logic        res_stall       = 1'b0;
	logic [7:0]  level;
	logic        lamp_on;
	logic [2:0]  action;
	logic        dimming;
	logic        dim_upward;

	// The item on the port, kept alongside it so the acceptance monitor sees
	// the typed-in result of a directed row.
	lamp_item_t drv_item = '0;

	// Lamp model state.
	logic [7:0]       m_level;
	logic             m_lit;
	logic [7:0]       m_memory;
	logic             m_dim;
	logic             m_up;
	logic [7:0]       last_sess;
	logic [15:0]      last_seq;
	logic [AGE_W-1:0] ka_age;
	logic [AGE_W-1:0] st_age;
	logic             st_pend;

	// Register copies held by the model.
	logic [7:0]  cf_step;
	logic [15:0] cf_timeout;
	logic [15:0] cf_interval;
	logic [7:0]  cf_default;

	// Results predicted for accepted items, oldest first.
	lamp_result_t lamp_q[$];
	lamp_result_t predicted;
	lamp_result_t oldest;
	lamp_item_t   dir_rows[$];

	// Packet identity that the generator last issued as a fresh, good packet.
	logic [7:0]  pkt_sess = 8'd16;
	logic [15:0] pkt_seq  = 16'd0;

	int send_pct     = 35;
	int recv_pct     = 88;
	int counted      = 0;
	int items_taken  = 0;
	int results_seen = 0;
	int errors       = 0;

	lamp_dimmer_command_controller #(.AGE_BITS(AGE_W)) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.evt_valid       (evt_valid),
		.evt_stall       (evt_stall),
		.event_kind      (event_kind),
		.command         (command),
		.packet_ok       (packet_ok),
		.session_id      (session_id),
		.sequence_number (sequence_number),
		.report_kind     (report_kind),
		.report_level    (report_level),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.level           (level),
		.lamp_on         (lamp_on),
		.action          (action),
		.dimming         (dimming),
		.dim_upward      (dim_upward)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Lamp model
	// ------------------------------------------------------------------

	// The model starts from the reset state of the block.
	initial begin
		m_level     = RST_LEVEL;
		m_lit       = 1'b0;
		m_memory    = RST_LEVEL;
		m_dim       = 1'b0;
		m_up        = 1'b1;
		last_sess   = '0;
		last_seq    = '0;
		ka_age      = '0;
		st_age      = '0;
		st_pend     = 1'b0;
		cf_step     = RST_STEP_SIZE;
		cf_timeout  = RST_TIMEOUT;
		cf_interval = RST_INTERVAL;
		cf_default  = RST_LEVEL;
	end

	// The level used when the lamp is dark: the last nonzero level, or the
	// default when nothing has been remembered.
	function automatic logic [7:0] fallback_level();
		return (m_memory != 8'd0) ? m_memory : cf_default;
	endfunction

	// Any nonzero level that is set, even the one kept at switch-off, is
	// remembered for the next switch-on.
	function automatic void set_light(input logic on, input logic [7:0] lvl);
		m_level = lvl;
		m_lit   = on && (lvl != 8'd0);
		if (lvl != 8'd0)
			m_memory = lvl;
	endfunction

	function automatic void end_dimming();
		m_dim = 1'b0;
		m_up  = !m_up;
	endfunction

	// Applies one item to the model and returns the result it must cause.
	function automatic lamp_result_t lamp_model(input lamp_item_t it);
		lamp_result_t r;
		int base;
		int stepv;
		int nxt;
		r.act = ACT_NONE;
		case (it.kind)
			EV_TICK: begin
				if (ka_age != '1)
					ka_age = ka_age + 1'b1;
				if (st_age != '1)
					st_age = st_age + 1'b1;
				if (m_dim) begin
					if (ka_age > cf_timeout) begin
						end_dimming();
					end else if (st_pend || st_age >= cf_interval) begin
						st_age  = '0;
						st_pend = 1'b0;
						base    = m_lit ? int'(m_level) : int'(fallback_level());
						stepv   = int'(cf_step);
						nxt     = m_up ? base + stepv : base - stepv;
						if (nxt < 0)
							nxt = 0;
						if (nxt > 255)
							nxt = 255;
						set_light(nxt > 0, nxt[7:0]);
						r.act = ACT_SEND;
					end
				end
			end
			EV_CMD: begin
				if (it.ok && !(it.sess == last_sess && it.seq == last_seq)) begin
					last_sess = it.sess;
					last_seq  = it.seq;
					case (it.cmd)
						CMD_ON: begin
							set_light(1'b1, (m_level != 8'd0) ? m_level : fallback_level());
							r.act = ACT_SEND;
						end
						CMD_OFF: begin
							set_light(1'b0, m_level);
							r.act = ACT_SEND;
						end
						CMD_GO_FIRST:  r.act = ACT_POS1;
						CMD_GO_SECOND: r.act = ACT_POS2;
						CMD_GO_ANY:    r.act = ACT_RANDOM;
						CMD_DIM_START: begin
							m_dim   = 1'b1;
							ka_age  = '0;
							st_pend = 1'b1;
						end
						CMD_KEEPALIVE: begin
							m_dim  = 1'b1;
							ka_age = '0;
						end
						CMD_DIM_STOP: begin
							if (m_dim)
								end_dimming();
						end
						default: ;
					endcase
				end
			end
			EV_REPORT: begin
				case (it.rkind)
					REP_OFF:   set_light(1'b0, m_level);
					REP_ON:    set_light(1'b1, fallback_level());
					REP_LEVEL: set_light(1'b1, it.rlevel);
					default:   ;
				endcase
			end
			default: ;
		endcase
		r.level = m_level;
		r.lit   = m_lit;
		r.dim   = m_dim;
		r.up    = m_up;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Monitors
	// ------------------------------------------------------------------

	// Every accepted item is run through the model at the edge that takes it.
	// A directed row with a typed-in result still advances the model, so the
	// rows after it stay in step.
	always @(posedge clk) begin
		if (arst_n && evt_valid && !evt_stall) begin
			predicted = lamp_model(drv_item);
			lamp_q.push_back(drv_item.fixed ? drv_item.want : predicted);
			items_taken++;
		end
	end

	// The receiver stalls at random; the share is set per phase.
	always @(posedge clk)
		res_stall <= ($urandom_range(99) < recv_pct);

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// Each accepted result is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (lamp_q.size() == 0) begin
				$display("%0t ns: result with nothing expected, level %0d action %0d",
					$time, level, action);
				errors++;
			end else begin
				oldest = lamp_q.pop_front();
				check_field("level", int'(oldest.level), int'(level));
				check_field("lamp_on", int'(oldest.lit), int'(lamp_on));
				check_field("action", int'(oldest.act), int'(action));
				check_field("dimming", int'(oldest.dim), int'(dimming));
				check_field("dim_upward", int'(oldest.up), int'(dim_upward));
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// Puts one item on the port, after a random number of idle cycles, and
	// holds it until the block takes it. Valid stays high into the next item
	// when no idle cycle follows.
	task automatic send_item(input lamp_item_t it, input bit count_it);
		while ($urandom_range(99) < send_pct) begin
			evt_valid <= 1'b0;
			@(posedge clk);
		end
		evt_valid       <= 1'b1;
		event_kind      <= it.kind;
		command         <= it.cmd;
		packet_ok       <= it.ok;
		session_id      <= it.sess;
		sequence_number <= it.seq;
		report_kind     <= it.rkind;
		report_level    <= it.rlevel;
		drv_item        <= it;
		do
			@(posedge clk);
		while (evt_stall);
		if (count_it)
			counted++;
	endtask

	// Lowers valid and waits until every result is back and the pipeline has
	// had time to empty. The first edge lets the monitor record the last item.
	task automatic wait_idle();
		evt_valid <= 1'b0;
		@(posedge clk);
		while (lamp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes one register and mirrors it into the model. Valid is left high
	// so that back-to-back writes need no extra cycle.
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_STEP_SIZE: cf_step     = val[7:0];
			REG_TIMEOUT:   cf_timeout  = val;
			REG_INTERVAL:  cf_interval = val;
			REG_DEFAULT:   cf_default  = val[7:0];
			default:       ;
		endcase
	endtask

	task automatic write_config(input logic [7:0] step, input logic [15:0] tmo,
		input logic [15:0] ivl, input logic [7:0] dflt);
		write_reg(REG_STEP_SIZE, {8'd0, step});
		write_reg(REG_TIMEOUT, tmo);
		write_reg(REG_INTERVAL, ivl);
		write_reg(REG_DEFAULT, {8'd0, dflt});
		cfg_valid <= 1'b0;
	endtask

	// Fields that an item kind does not use are filled with noise as well.
	function automatic lamp_item_t noise_item();
		lamp_item_t it;
		it        = '0;
		it.kind   = 2'($urandom_range(3));
		it.cmd    = 4'($urandom_range(15));
		it.ok     = 1'($urandom_range(1));
		it.sess   = 8'($urandom);
		it.seq    = 16'($urandom);
		it.rkind  = 2'($urandom_range(3));
		it.rlevel = 8'($urandom);
		return it;
	endfunction

	function automatic lamp_item_t tick_item();
		lamp_item_t it;
		it      = noise_item();
		it.kind = EV_TICK;
		return it;
	endfunction

	// A good packet with an identity never used just before, so that it gets
	// past the duplicate filter.
	function automatic lamp_item_t radio_cmd(input logic [3:0] cmd);
		lamp_item_t it;
		it = noise_item();
		if ($urandom_range(7) == 0)
			pkt_sess = 8'($urandom);
		pkt_seq = pkt_seq + 1'b1;
		it.kind = EV_CMD;
		it.cmd  = cmd;
		it.ok   = 1'b1;
		it.sess = pkt_sess;
		it.seq  = pkt_seq;
		return it;
	endfunction

	// Reports lean on the level extremes now and then.
	function automatic lamp_item_t lamp_report();
		lamp_item_t it;
		it       = noise_item();
		it.kind  = EV_REPORT;
		it.rkind = 2'($urandom_range(3));
		case ($urandom_range(7))
			0:       it.rlevel = 8'd0;
			1:       it.rlevel = LEVEL_MAX;
			default: ;
		endcase
		return it;
	endfunction

	// A press-and-hold: dim start, a run of ticks with or without keepalives
	// so that some holds time out, and sometimes a release.
	task automatic dim_episode();
		int  ticks;
		bit  feed;
		ticks = $urandom_range(1, 45);
		feed  = 1'($urandom_range(1));
		if ($urandom_range(1))
			send_item(radio_cmd(CMD_ON), 1'b1);
		send_item(radio_cmd(CMD_DIM_START), 1'b1);
		for (int i = 0; i < ticks; i++) begin
			if (feed && $urandom_range(4) == 0)
				send_item(radio_cmd(CMD_KEEPALIVE), 1'b1);
			else
				send_item(tick_item(), 1'b1);
			if ($urandom_range(19) == 0)
				send_item(lamp_report(), 1'b1);
		end
		if ($urandom_range(1))
			send_item(radio_cmd(CMD_DIM_STOP), 1'b1);
	endtask

	// Mostly well-formed traffic. Repeated and failed packets, and pure noise,
	// are mixed in but do not count toward the phase length.
	task automatic run_random(input int n);
		int target;
		int pick;
		lamp_item_t it;
		target = counted + n;
		while (counted < target) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				dim_episode();
			end else if (pick < 60) begin
				send_item(lamp_report(), 1'b1);
			end else if (pick < 75) begin
				send_item(radio_cmd(4'($urandom_range(15))), 1'b1);
			end else if (pick < 85) begin
				it      = noise_item();
				it.kind = EV_CMD;
				if ($urandom_range(1)) begin
					// Same identity as the last good packet: a retransmission.
					it.ok   = 1'b1;
					it.sess = pkt_sess;
					it.seq  = pkt_seq;
				end else begin
					it.ok = 1'b0;
				end
				send_item(it, 1'b0);
			end else begin
				send_item(noise_item(), 1'b0);
			end
		end
	endtask

	task automatic run_phase(input int sp, input int rp, input logic [7:0] step,
		input logic [15:0] tmo, input logic [15:0] ivl, input logic [7:0] dflt,
		input int n);
		send_pct = sp;
		recv_pct = rp;
		wait_idle();
		write_config(step, tmo, ivl, dflt);
		run_random(n);
	endtask

	task automatic add_row(input logic [1:0] kind, input logic [3:0] cmd,
		input logic ok, input logic [7:0] sess, input logic [15:0] seq,
		input logic [1:0] rk, input logic [7:0] rl, input logic fixed,
		input lamp_result_t want);
		lamp_item_t it;
		it.kind   = kind;
		it.cmd    = cmd;
		it.ok     = ok;
		it.sess   = sess;
		it.seq    = seq;
		it.rkind  = rk;
		it.rlevel = rl;
		it.fixed  = fixed;
		it.want   = want;
		dir_rows.push_back(it);
	endtask

	// Directed items. They run with a timeout of 4 and a step interval of 2
	// so that holds time out within a few ticks; step size stays at 16.
	task automatic build_table();
		// The reset state shows up on the first tick.
		add_row(EV_TICK, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_OFF, 8'd0, TYPED,
			{8'd160, 1'b0, ACT_NONE, 1'b0, 1'b1});
		// Session 0, sequence 0 equals the duplicate record after reset.
		add_row(EV_CMD, CMD_ON, 1'b1, 8'd0, 16'd0, REP_OFF, 8'd0, TYPED,
			{8'd160, 1'b0, ACT_NONE, 1'b0, 1'b1});
		add_row(EV_CMD, CMD_ON, 1'b1, 8'd1, 16'd1, REP_OFF, 8'd0, TYPED,
			{8'd160, 1'b1, ACT_SEND, 1'b0, 1'b1});
		// A repeated packet and a packet that failed its check are dropped.
		add_row(EV_CMD, CMD_OFF, 1'b1, 8'd1, 16'd1, REP_OFF, 8'd0, TYPED,
			{8'd160, 1'b1, ACT_NONE, 1'b0, 1'b1});
		add_row(EV_CMD, CMD_OFF, 1'b0, 8'd1, 16'd2, REP_OFF, 8'd0, TYPED,
			{8'd160, 1'b1, ACT_NONE, 1'b0, 1'b1});
		// Dim start at the top identity; the first step comes on the next tick.
		add_row(EV_CMD, CMD_DIM_START, 1'b1, 8'hFF, 16'hFFFF, REP_OFF, 8'd0, TYPED,
			{8'd160, 1'b1, ACT_NONE, 1'b1, 1'b1});
		add_row(EV_TICK, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_OFF, 8'd0, TYPED,
			{8'd176, 1'b1, ACT_SEND, 1'b1, 1'b1});
		add_row(EV_TICK, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_OFF, 8'd0, BY_MODEL, '0);
		add_row(EV_CMD, CMD_KEEPALIVE, 1'b1, 8'd2, 16'd0, REP_OFF, 8'd0, BY_MODEL, '0);
		add_row(EV_REPORT, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_LEVEL, 8'd255, TYPED,
			{8'd255, 1'b1, ACT_NONE, 1'b1, 1'b1});
		// This tick steps up from full brightness and must clamp.
		add_row(EV_TICK, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_OFF, 8'd0, BY_MODEL, '0);
		add_row(EV_CMD, CMD_DIM_STOP, 1'b1, 8'd2, 16'd1, REP_OFF, 8'd0, BY_MODEL, '0);
		// A stop while not dimming changes nothing.
		add_row(EV_CMD, CMD_DIM_STOP, 1'b1, 8'd2, 16'd2, REP_OFF, 8'd0, BY_MODEL, '0);
		add_row(EV_REPORT, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_LEVEL, 8'd0, TYPED,
			{8'd0, 1'b0, ACT_NONE, 1'b0, 1'b0});
		// Switching on from level zero brings back the remembered level.
		add_row(EV_CMD, CMD_ON, 1'b1, 8'd3, 16'd3, REP_OFF, 8'd0, TYPED,
			{8'd255, 1'b1, ACT_SEND, 1'b0, 1'b0});
		add_row(EV_CMD, CMD_GO_FIRST, 1'b1, 8'd3, 16'd4, REP_OFF, 8'd0, TYPED,
			{8'd255, 1'b1, ACT_POS1, 1'b0, 1'b0});
		add_row(EV_CMD, CMD_GO_SECOND, 1'b1, 8'd3, 16'd5, REP_OFF, 8'd0, TYPED,
			{8'd255, 1'b1, ACT_POS2, 1'b0, 1'b0});
		add_row(EV_CMD, CMD_GO_ANY, 1'b1, 8'd3, 16'd6, REP_OFF, 8'd0, TYPED,
			{8'd255, 1'b1, ACT_RANDOM, 1'b0, 1'b0});
		// An unused command code and a state request are accepted but inert.
		add_row(EV_CMD, CMD_SPARE, 1'b1, 8'd3, 16'd7, REP_OFF, 8'd0, TYPED,
			{8'd255, 1'b1, ACT_NONE, 1'b0, 1'b0});
		add_row(EV_CMD, CMD_STATE, 1'b1, 8'd3, 16'd8, REP_SPARE, 8'hAA, TYPED,
			{8'd255, 1'b1, ACT_NONE, 1'b0, 1'b0});
		// The unused event kind and the unused report kind are ignored.
		add_row(EV_SPARE, CMD_ON, 1'b1, 8'h55, 16'h5555, REP_LEVEL, 8'd1, TYPED,
			{8'd255, 1'b1, ACT_NONE, 1'b0, 1'b0});
		add_row(EV_REPORT, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_SPARE, 8'd7, TYPED,
			{8'd255, 1'b1, ACT_NONE, 1'b0, 1'b0});
		add_row(EV_REPORT, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_OFF, 8'd9, TYPED,
			{8'd255, 1'b0, ACT_NONE, 1'b0, 1'b0});
		// A downward hold from a dark lamp starts at the remembered level and
		// then runs out of keepalives.
		add_row(EV_CMD, CMD_DIM_START, 1'b1, 8'd4, 16'd9, REP_OFF, 8'd0, BY_MODEL, '0);
		repeat (5)
			add_row(EV_TICK, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_OFF, 8'd0, BY_MODEL, '0);
		add_row(EV_REPORT, CMD_IDLE, 1'b0, 8'd0, 16'd0, REP_ON, 8'd0, BY_MODEL, '0);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		build_table();
		write_config(RST_STEP_SIZE, 16'd4, 16'd2, RST_LEVEL);
		foreach (dir_rows[i])
			send_item(dir_rows[i], 1'b0);

		// Sender idles lightly while the receiver stalls heavily.
		run_phase(35, 88, 8'd16, 16'd12, 16'd3, 8'd160, 220);
		run_phase(35, 88, 8'd255, 16'd1, 16'd1, 8'd1, 220);
		// Then the other way round.
		run_phase(88, 35, 8'd40, 16'd30, 16'd5, 8'd100, 220);
		run_phase(88, 35, 8'($urandom_range(1, 255)), 16'($urandom_range(2, 40)),
			16'($urandom_range(1, 10)), 8'($urandom_range(1, 255)), 220);
		// And flat out.
		run_phase(0, 0, 8'd7, 16'd20, 16'd2, 8'd200, 220);
		run_phase(0, 0, 8'd1, 16'd65534, 16'd65534, 8'd255, 220);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Ran %0d items (%0d directed), checked %0d results over six register settings.",
			items_taken, dir_rows.size(), results_seen);
		$display("Idling mixes: heavy receiver stall, heavy sender idle, none.");
		if (errors == 0 && lamp_q.size() == 0)
			$display("lamp_dimmer_command_controller: match");
		else
			$display("lamp_dimmer_command_controller: mismatch");
		$finish;
	end

	// Several times the slowest correct run.
	initial begin
		#1000000;
		$display("Timed out with %0d results still expected.", lamp_q.size());
		$display("lamp_dimmer_command_controller: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ldcc_pkg.sv
hw/rtl/ldcc_lamp.sv
hw/rtl/lamp_dimmer_command_controller.sv
verif/testbench.sv
